FILE: src/rotary_dial_mf_sequencer_macros.svh
// assertion macros for the rotary dial mf sequencer
// used by modules that hold clk_i and rst_ni; no other dependencies
`ifndef ROTARY_DIAL_MF_SEQUENCER_MACROS_SVH
`define ROTARY_DIAL_MF_SEQUENCER_MACROS_SVH

// plain invariant, checked at every clock edge out of reset
`define RDMS_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("rdms invariant violated");

// antecedent implies consequent, property written by the caller
`define RDMS_ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rdms property violated");

`endif

FILE: src/rdms_pkg.sv
// shared types, constants and tone tables of the rotary dial mf sequencer
// no dependencies
`default_nettype none

package rdms_pkg;

  localparam int STORE_DEPTH = 16;
  localparam int StoreIdxW   = $clog2(STORE_DEPTH);
  localparam int FillW       = $clog2(STORE_DEPTH + 1);

  localparam int QuietW = 16;
  localparam int CfgW   = 16;

  localparam logic [CfgW-1:0] SpinTimeoutReset  = 16'd100;
  localparam logic [CfgW-1:0] DebounceTimeReset = 16'd10;

  localparam logic [3:0]  DigitKp   = 4'd10;
  localparam logic [3:0]  DigitSt   = 4'd11;
  localparam logic [3:0]  PulseMax  = 4'd10;
  localparam logic [11:0] ChirpHz   = 12'd2600;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_KP   = 2'd1,
    OP_ST   = 2'd2,
    OP_2600 = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ACT_MF       = 3'd0,
    ACT_PULSE    = 3'd1,
    ACT_SEIZE    = 3'd2,
    ACT_NOTE_ON  = 3'd3,
    ACT_NOTE_OFF = 3'd4
  } action_e;

  typedef enum logic {
    CFG_SPIN_TIMEOUT  = 1'b0,
    CFG_DEBOUNCE_TIME = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    SEL_TIMEOUT  = 1'b0,
    SEL_DEBOUNCE = 1'b1
  } cmp_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TIMEOUT,
    S_DEBOUNCE,
    S_KEY,
    S_ST_MF,
    S_REPLAY
  } state_e;

  typedef struct packed {
    logic [1:0] op;
    logic       dial_level;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  digit;
    logic [11:0] low_hz;
    logic [10:0] high_hz;
    logic        last;
  } out_item_t;

  function automatic logic [11:0] mf_low_hz(logic [3:0] d);
    logic [11:0] hz;
    case (d)
      4'd0:    hz = 12'd1300;
      4'd1:    hz = 12'd700;
      4'd2:    hz = 12'd700;
      4'd3:    hz = 12'd900;
      4'd4:    hz = 12'd700;
      4'd5:    hz = 12'd900;
      4'd6:    hz = 12'd1100;
      4'd7:    hz = 12'd700;
      4'd8:    hz = 12'd900;
      4'd9:    hz = 12'd1100;
      4'd10:   hz = 12'd1100;
      4'd11:   hz = 12'd1500;
      default: hz = 12'd0;
    endcase
    return hz;
  endfunction

  function automatic logic [10:0] mf_high_hz(logic [3:0] d);
    logic [10:0] hz;
    case (d)
      4'd0:    hz = 11'd1500;
      4'd1:    hz = 11'd900;
      4'd2:    hz = 11'd1100;
      4'd3:    hz = 11'd1100;
      4'd4:    hz = 11'd1300;
      4'd5:    hz = 11'd1300;
      4'd6:    hz = 11'd1300;
      4'd7:    hz = 11'd1500;
      4'd8:    hz = 11'd1500;
      4'd9:    hz = 11'd1500;
      4'd10:   hz = 11'd1700;
      4'd11:   hz = 11'd1700;
      default: hz = 11'd0;
    endcase
    return hz;
  endfunction

  function automatic out_item_t mf_item(logic [3:0] d, logic last);
    out_item_t r;
    r.action  = ACT_MF;
    r.digit   = d;
    r.low_hz  = mf_low_hz(d);
    r.high_hz = mf_high_hz(d);
    r.last    = last;
    return r;
  endfunction

  function automatic out_item_t plain_item(action_e act, logic [11:0] lo, logic last);
    out_item_t r;
    r.action  = act;
    r.digit   = '0;
    r.low_hz  = lo;
    r.high_hz = '0;
    r.last    = last;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/rdms_cmp_unit.sv
// shared saturating counter step and 16-bit magnitude compare
// depends on rdms_pkg
`default_nettype none

module rdms_cmp_unit (
  input  wire logic [rdms_pkg::QuietW-1:0] quiet_i,
  input  wire rdms_pkg::cmp_sel_e          sel_i,
  input  wire logic [rdms_pkg::CfgW-1:0]   spin_timeout_i,
  input  wire logic [rdms_pkg::CfgW-1:0]   debounce_time_i,
  output logic      [rdms_pkg::QuietW-1:0] quiet_inc_o,
  output logic                             gt_o
);
  import rdms_pkg::*;

  logic [QuietW-1:0] cmp_a;
  logic [CfgW-1:0]   cmp_b;

  // saturate at all ones
  assign quiet_inc_o = (&quiet_i) ? quiet_i : quiet_i + 1'b1;

  always_comb begin
    unique case (sel_i)
      SEL_TIMEOUT: begin
        cmp_a = quiet_inc_o;
        cmp_b = spin_timeout_i;
      end
      SEL_DEBOUNCE: begin
        cmp_a = quiet_i;
        cmp_b = debounce_time_i;
      end
    endcase
  end

  assign gt_o = cmp_a > cmp_b;

endmodule

`default_nettype wire

FILE: src/rotary_dial_mf_sequencer.sv
// top level of the rotary dial mf sequencer: control sequencer, digit store, output register
// depends on rdms_pkg, rdms_cmp_unit and rotary_dial_mf_sequencer_macros.svh
//
// usage
//   input channel: in_valid_i / in_stall_o carry one in_item_t per transaction, either a
//   1 ms tick with the raw dial level or a KP, ST or 2600 key press
//   output channel: out_valid_o / out_stall_i carry out_item_t results (tone actions with
//   their mf frequency pair); the final result of a transaction has last set, and a
//   transaction may cause no result at all
//   config channel: cfg_valid_i / cfg_ready_o, index 0 spin_timeout, 1 debounce_time;
//   cfg_ready_o is always high, write only while the block is idle
// timing
//   one transaction at a time through a small sequencer around a shared compare unit
//   tick: timeout compare step, then debounce compare step
//   KP: key step only, ST: key step, plus the ST pair step when it toggles pulse-dial mode
//   2600: key step (seize notice), then a replay step per stored digit, at most 16 digits
//   the first result is registered and appears in the cycle after its step; in_stall_o is high while busy
// reset
//   rst_ni clears all control state and the store fill count at once; no clearing pass
// back pressure
//   a result waits in the output register while out_stall_i is high, and each step
//   that can produce a result (timeout, key, ST pair, replay) waits for the register to free up
`default_nettype none

module rotary_dial_mf_sequencer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // input items
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire rdms_pkg::in_item_t           in_data_i,
  // results
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output rdms_pkg::out_item_t               out_data_o,
  // register writes
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic                         cfg_index_i,
  input  wire logic [rdms_pkg::CfgW-1:0]    cfg_data_i
);
  import rdms_pkg::*;

  `include "rotary_dial_mf_sequencer_macros.svh"

  // configuration registers
  logic [CfgW-1:0] spin_timeout_q, debounce_time_q;

  // sequencer and latched transaction
  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   level_q, level_d;

  // dial decoder state
  logic [QuietW-1:0] quiet_q, quiet_d;
  logic [3:0]        pulse_count_q, pulse_count_d;
  logic              pending_q, pending_d;
  logic              prev_level_q, prev_level_d;
  logic              stable_q, stable_d;

  // key machine state
  logic       record_q, record_d;
  logic       pulse_mode_q, pulse_mode_d;
  logic [3:0] prev_digit_q, prev_digit_d;
  logic       store_valid_q, store_valid_d;

  // digit store: filled as a prefix, so a fill count stands for the empty marks
  logic [3:0]           store_mem [STORE_DEPTH];
  logic [FillW-1:0]     fill_q, fill_d;
  logic [StoreIdxW-1:0] idx_q, idx_d;
  logic [3:0]           rd_data_q;
  logic                 store_we;
  logic [3:0]           store_wdata;

  // output register
  logic      out_valid_q;
  out_item_t out_q;
  logic      emit;
  out_item_t res;
  logic      out_free;

  // shared compare unit
  cmp_sel_e          cmp_sel;
  logic [QuietW-1:0] quiet_inc;
  logic              cmp_gt;

  // dialed digit: a saturated count of ten is digit zero
  logic [3:0] dial_digit, pulse_num;
  logic       store_room;
  logic       replay_last;

  rdms_cmp_unit u_cmp (
    .quiet_i         (quiet_q),
    .sel_i           (cmp_sel),
    .spin_timeout_i  (spin_timeout_q),
    .debounce_time_i (debounce_time_q),
    .quiet_inc_o     (quiet_inc),
    .gt_o            (cmp_gt)
  );

  assign dial_digit  = (pulse_count_q >= PulseMax) ? 4'd0 : pulse_count_q;
  assign pulse_num   = (dial_digit == 4'd0) ? PulseMax : dial_digit;
  assign store_room  = fill_q < FillW'(STORE_DEPTH);
  assign replay_last = ({1'b0, idx_q} + 1'b1) == fill_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spin_timeout_q  <= SpinTimeoutReset;
      debounce_time_q <= DebounceTimeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_SPIN_TIMEOUT:  spin_timeout_q  <= cfg_data_i;
        CFG_DEBOUNCE_TIME: debounce_time_q <= cfg_data_i;
      endcase
    end
  end

  // sequencer next state and outputs
  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    level_d       = level_q;
    quiet_d       = quiet_q;
    pulse_count_d = pulse_count_q;
    pending_d     = pending_q;
    prev_level_d  = prev_level_q;
    stable_d      = stable_q;
    record_d      = record_q;
    pulse_mode_d  = pulse_mode_q;
    prev_digit_d  = prev_digit_q;
    store_valid_d = store_valid_q;
    fill_d        = fill_q;
    idx_d         = idx_q;
    store_we      = 1'b0;
    store_wdata   = dial_digit;
    emit          = 1'b0;
    res           = mf_item(dial_digit, 1'b1);
    cmp_sel       = SEL_TIMEOUT;

    unique case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (in_valid_i) begin
          op_d    = op_e'(in_data_i.op);
          level_d = in_data_i.dial_level;
          state_d = (op_e'(in_data_i.op) == OP_TICK) ? S_TIMEOUT : S_KEY;
        end
      end

      // quiet counter step and spin timeout check
      S_TIMEOUT: begin
        cmp_sel = SEL_TIMEOUT;
        if (out_free) begin
          quiet_d = (level_q != prev_level_q) ? '0 : quiet_inc;
          if (cmp_gt && pending_q) begin
            if (record_q && store_room) begin
              store_we    = 1'b1;
              store_wdata = dial_digit;
              fill_d      = fill_q + 1'b1;
            end
            prev_digit_d  = dial_digit;
            emit          = 1'b1;
            if (pulse_mode_q) begin
              res       = plain_item(ACT_PULSE, ChirpHz, 1'b1);
              res.digit = pulse_num;
            end else begin
              res = mf_item(dial_digit, 1'b1);
            end
            pending_d     = 1'b0;
            pulse_count_d = '0;
          end
          state_d = S_DEBOUNCE;
        end
      end

      // debounce check and rising edge count
      S_DEBOUNCE: begin
        cmp_sel = SEL_DEBOUNCE;
        if (cmp_gt && (level_q != stable_q)) begin
          stable_d = level_q;
          if (level_q) begin
            if (pulse_count_q < PulseMax) begin
              pulse_count_d = pulse_count_q + 1'b1;
            end
            pending_d = 1'b1;
          end
        end
        prev_level_d = level_q;
        state_d      = S_IDLE;
      end

      S_KEY: begin
        if (out_free) begin
          emit = 1'b1;
          unique case (op_q)
            OP_KP: begin
              // KP goes into the store only right after a zero
              if (record_q && (prev_digit_q == 4'd0) && store_room) begin
                store_we    = 1'b1;
                store_wdata = DigitKp;
                fill_d      = fill_q + 1'b1;
              end
              if (prev_digit_q == DigitKp) begin
                prev_digit_d = 4'd0;
                if (record_q) begin
                  record_d = 1'b0;
                  res      = plain_item(ACT_NOTE_OFF, 12'd0, 1'b1);
                  if (fill_q < FillW'(2)) begin
                    fill_d        = '0;
                    store_valid_d = 1'b0;
                  end else begin
                    store_valid_d = 1'b1;
                  end
                end else begin
                  fill_d   = '0;
                  record_d = 1'b1;
                  res      = plain_item(ACT_NOTE_ON, 12'd0, 1'b1);
                end
              end else begin
                prev_digit_d = DigitKp;
                res          = mf_item(DigitKp, 1'b1);
              end
              state_d = S_IDLE;
            end
            OP_ST: begin
              if (record_q && store_room) begin
                store_we    = 1'b1;
                store_wdata = DigitSt;
                fill_d      = fill_q + 1'b1;
              end
              if (prev_digit_q == DigitSt) begin
                // toggle notice first, the ST pair follows
                if (pulse_mode_q) begin
                  pulse_mode_d = 1'b0;
                  prev_digit_d = 4'd0;
                  res          = plain_item(ACT_NOTE_OFF, 12'd0, 1'b0);
                end else begin
                  pulse_mode_d = 1'b1;
                  res          = plain_item(ACT_NOTE_ON, 12'd0, 1'b0);
                end
                state_d = S_ST_MF;
              end else begin
                prev_digit_d = DigitSt;
                res          = mf_item(DigitSt, 1'b1);
                state_d      = S_IDLE;
              end
            end
            OP_2600: begin
              res = plain_item(ACT_SEIZE, ChirpHz, !(store_valid_q && (fill_q != '0)));
              state_d = (store_valid_q && (fill_q != '0)) ? S_REPLAY : S_IDLE;
            end
            OP_TICK: begin
              emit    = 1'b0;
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_ST_MF: begin
        if (out_free) begin
          emit    = 1'b1;
          res     = mf_item(DigitSt, 1'b1);
          state_d = S_IDLE;
        end
      end

      // one stored digit per cycle while the output register is free, read data registered one step ahead
      S_REPLAY: begin
        if (out_free) begin
          emit = 1'b1;
          res  = mf_item(rd_data_q, replay_last);
          if (replay_last) begin
            idx_d   = '0;
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      op_q          <= OP_TICK;
      level_q       <= 1'b0;
      quiet_q       <= '0;
      pulse_count_q <= '0;
      pending_q     <= 1'b0;
      prev_level_q  <= 1'b0;
      stable_q      <= 1'b0;
      record_q      <= 1'b0;
      pulse_mode_q  <= 1'b0;
      prev_digit_q  <= '0;
      store_valid_q <= 1'b0;
      fill_q        <= '0;
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      op_q          <= op_d;
      level_q       <= level_d;
      quiet_q       <= quiet_d;
      pulse_count_q <= pulse_count_d;
      pending_q     <= pending_d;
      prev_level_q  <= prev_level_d;
      stable_q      <= stable_d;
      record_q      <= record_d;
      pulse_mode_q  <= pulse_mode_d;
      prev_digit_q  <= prev_digit_d;
      store_valid_q <= store_valid_d;
      fill_q        <= fill_d;
      idx_q         <= idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  // digit store, write at the fill point, registered read at the replay index
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[fill_q[StoreIdxW-1:0]] <= store_wdata;
    end
    rd_data_q <= store_mem[idx_d];
  end

  `RDMS_ASSERT(a_fill_in_range, fill_q <= FillW'(STORE_DEPTH))
  `RDMS_ASSERT(a_pulse_sat, pulse_count_q <= PulseMax)
  `RDMS_ASSERT_PROP(a_replay_has_data, (state_q == S_REPLAY) |-> (store_valid_q && (fill_q != '0)))
  `RDMS_ASSERT_PROP(a_valid_store_size, (store_valid_q && !record_q) |-> (fill_q >= FillW'(2)))
  `RDMS_ASSERT_PROP(a_accept_busy, (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))

endmodule

`default_nettype wire
